// File: sv/bpl_pkg.sv
package bpl_pkg;

    // List geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Stream packing
    localparam int S_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + VALUE_W + 7) / 8) * 8;

    // Request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_TRAVERSE  = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_INS,
        OP_DEL,
        OP_TRAV,
        OP_NOP
    } op_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FWD,
        BK_BWD
    } bk_state_t;

    // Classified request: at_end selects the tail, check_range flags delete-at
    typedef struct packed {
        op_kind_t                      kind;
        logic                          at_end;
        logic                          check_range;
        logic [POS_W-1:0]              idx;
        logic signed [DATA_WIDTH-1:0]  word;
    } op_t;

    // One result item
    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  value;
        logic                       direction;
        logic                       last;
    } res_t;

    // Sign-extend a stored word and fit it to the result field
    function automatic logic signed [VALUE_W-1:0] to_field(
        input logic signed [DATA_WIDTH-1:0] w);
        return VALUE_W'(w);
    endfunction

    // Fit an input word to the stored width
    function automatic logic signed [DATA_WIDTH-1:0] to_word(
        input logic signed [VALUE_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

endpackage

// File: sv/bounded_positional_list.sv
// Channel  | Ports                        | Contents (low bit up)
// ---------+------------------------------+----------------------------------------
// request  | s_tvalid s_tready s_tdata    | tdata: value[31:0], position[36:32]
//          | s_tuser                      | tuser: cmd[2:0]
// result   | m_tvalid m_tready m_tdata    | tdata: status[1:0], value_res[33:2]
//          | m_tuser m_tlast              | tuser: direction; tlast: last
//
// Insert, delete and unknown commands give one result each; a traversal of a non-empty
// list gives 2*count results, one per cycle unless the consumer stalls, through the single
// read mux of the cell array. Requests pass the front register, then the request queue.
// Reset clears the count, the control state and the valid flags; cell contents stay undefined until written.
// Either side may stall: the request queue and the result register decouple them.
module bounded_positional_list (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpl_pkg::S_TDATA_W-1:0]   s_tdata,   // value, position
    input  logic [bpl_pkg::CMD_W-1:0]       s_tuser,   // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpl_pkg::M_TDATA_W-1:0]   m_tdata,   // status, value_res
    output logic                            m_tuser,   // direction
    output logic                            m_tlast
);

    logic           q_in_valid;
    logic           q_in_ready;
    bpl_pkg::op_t   q_in_op;
    logic           q_out_valid;
    logic           q_out_ready;
    bpl_pkg::op_t   q_out_op;
    bpl_pkg::res_t  res;

    bpl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_value    (s_tdata[bpl_pkg::VALUE_W-1:0]),
        .in_position (s_tdata[bpl_pkg::VALUE_W +: bpl_pkg::POS_W]),
        .q_valid     (q_in_valid),
        .q_ready     (q_in_ready),
        .q_op        (q_in_op)
    );

    bpl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_op    (q_in_op),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_op     (q_out_op)
    );

    bpl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_out_valid),
        .q_ready   (q_out_ready),
        .q_op      (q_out_op),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result fields
    assign m_tdata = bpl_pkg::M_TDATA_W'({res.value, res.status});
    assign m_tuser = res.direction;
    assign m_tlast = res.last;

endmodule

// File: sv/bpl_front.sv
module bpl_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bpl_pkg::CMD_W-1:0]   in_cmd,
    input  logic signed [bpl_pkg::VALUE_W-1:0] in_value,
    input  logic [bpl_pkg::POS_W-1:0]   in_position,
    output logic                        q_valid,
    input  logic                        q_ready,
    output bpl_pkg::op_t                q_op
);

    logic          valid_reg;
    logic          valid_next;
    bpl_pkg::op_t  op_reg;
    bpl_pkg::op_t  op_next;
    logic          accept;

    assign in_ready = !valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign q_valid  = valid_reg;
    assign q_op     = op_reg;

    // Classify the command into a list operation
    always_comb begin
        op_next             = '0;
        op_next.word        = bpl_pkg::to_word(in_value);
        op_next.kind        = bpl_pkg::OP_NOP;
        op_next.at_end      = 1'b0;
        op_next.check_range = 1'b0;
        op_next.idx         = '0;
        case (bpl_pkg::cmd_t'(in_cmd))
            bpl_pkg::CMD_INS_FRONT: begin
                op_next.kind = bpl_pkg::OP_INS;
            end
            bpl_pkg::CMD_INS_BACK: begin
                op_next.kind   = bpl_pkg::OP_INS;
                op_next.at_end = 1'b1;
            end
            bpl_pkg::CMD_INS_AT: begin
                op_next.kind = bpl_pkg::OP_INS;
                if (in_position > bpl_pkg::POS_W'(1)) begin
                    op_next.idx = in_position - bpl_pkg::POS_W'(1);
                end
            end
            bpl_pkg::CMD_DEL_FRONT: begin
                op_next.kind = bpl_pkg::OP_DEL;
            end
            bpl_pkg::CMD_DEL_BACK: begin
                op_next.kind   = bpl_pkg::OP_DEL;
                op_next.at_end = 1'b1;
            end
            bpl_pkg::CMD_DEL_AT: begin
                op_next.kind        = bpl_pkg::OP_DEL;
                op_next.check_range = 1'b1;
                if (in_position != '0) begin
                    op_next.idx = in_position - bpl_pkg::POS_W'(1);
                end
            end
            bpl_pkg::CMD_TRAVERSE: begin
                op_next.kind = bpl_pkg::OP_TRAV;
            end
            default: begin
                op_next.kind = bpl_pkg::OP_NOP;
            end
        endcase
    end

    // Hold the request until the queue takes it
    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= op_next;
        end
    end

endmodule

// File: sv/bpl_queue.sv
module bpl_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  bpl_pkg::op_t  push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bpl_pkg::op_t  pop_op
);

    bpl_pkg::op_t                 mem_reg [bpl_pkg::QDEPTH];
    logic [bpl_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [bpl_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [bpl_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [bpl_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [bpl_pkg::QLVL_W-1:0]   level_reg;
    logic [bpl_pkg::QLVL_W-1:0]   level_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (level_reg != bpl_pkg::QLVL_W'(bpl_pkg::QDEPTH));
    assign pop_valid  = (level_reg != '0);
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push) begin
            if (wr_ptr_reg == bpl_pkg::QPTR_W'(bpl_pkg::QDEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + bpl_pkg::QPTR_W'(1);
            end
        end
        if (do_pop) begin
            if (rd_ptr_reg == bpl_pkg::QPTR_W'(bpl_pkg::QDEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + bpl_pkg::QPTR_W'(1);
            end
        end
        if (do_push && !do_pop) begin
            level_next = level_reg + bpl_pkg::QLVL_W'(1);
        end else if (do_pop && !do_push) begin
            level_next = level_reg - bpl_pkg::QLVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: sv/bpl_back.sv
module bpl_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  bpl_pkg::op_t  q_op,
    output logic          out_valid,
    input  logic          out_ready,
    output bpl_pkg::res_t out_res
);

    logic signed [bpl_pkg::DATA_WIDTH-1:0] cells_reg  [bpl_pkg::CAPACITY];
    logic signed [bpl_pkg::DATA_WIDTH-1:0] cells_next [bpl_pkg::CAPACITY];
    logic [bpl_pkg::CNT_W-1:0]  count_reg;
    logic [bpl_pkg::CNT_W-1:0]  count_next;
    logic [bpl_pkg::IDX_W-1:0]  trav_idx_reg;
    logic [bpl_pkg::IDX_W-1:0]  trav_idx_next;
    bpl_pkg::bk_state_t         state_reg;
    bpl_pkg::bk_state_t         state_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    bpl_pkg::res_t              res_reg;
    bpl_pkg::res_t              res_next;

    logic                       can_load;
    logic                       pop;
    logic                       out_load;
    logic                       full;
    logic                       empty;
    logic                       trav_at_tail;
    logic                       trav_at_head;
    logic                       range_err;
    logic [bpl_pkg::CNT_W-1:0]  ins_idx;
    logic [bpl_pkg::CNT_W-1:0]  del_idx;
    logic [bpl_pkg::IDX_W-1:0]  rd_idx;
    logic signed [bpl_pkg::DATA_WIDTH-1:0] rd_word;

    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign q_ready   = pop;

    assign full  = (count_reg == bpl_pkg::CNT_W'(bpl_pkg::CAPACITY));
    assign empty = (count_reg == '0);
    assign trav_at_tail = (bpl_pkg::CNT_W'(trav_idx_reg) == count_reg - bpl_pkg::CNT_W'(1));
    assign trav_at_head = (trav_idx_reg == '0);

    // Resolve positions against the current count
    always_comb begin
        if (q_op.at_end ||
            bpl_pkg::CMP_W'(q_op.idx) > bpl_pkg::CMP_W'(count_reg)) begin
            ins_idx = count_reg;
        end else begin
            ins_idx = bpl_pkg::CNT_W'(q_op.idx);
        end
        if (q_op.at_end) begin
            del_idx = count_reg - bpl_pkg::CNT_W'(1);
        end else begin
            del_idx = bpl_pkg::CNT_W'(q_op.idx);
        end
        range_err = q_op.check_range &&
                    (bpl_pkg::CMP_W'(q_op.idx) >= bpl_pkg::CMP_W'(count_reg));
    end

    // Single read port over the cell array
    assign rd_idx  = (state_reg == bpl_pkg::BK_IDLE) ? del_idx[bpl_pkg::IDX_W-1:0]
                                                     : trav_idx_reg;
    assign rd_word = cells_reg[rd_idx];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpl_pkg::BK_IDLE: begin
                if (q_valid && can_load && q_op.kind == bpl_pkg::OP_TRAV && !empty) begin
                    state_next = bpl_pkg::BK_FWD;
                end
            end
            bpl_pkg::BK_FWD: begin
                if (can_load && trav_at_tail) begin
                    state_next = bpl_pkg::BK_BWD;
                end
            end
            bpl_pkg::BK_BWD: begin
                if (can_load && trav_at_head) begin
                    state_next = bpl_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = bpl_pkg::BK_IDLE;
            end
        endcase
    end

    // Execute requests and emit results
    always_comb begin
        pop           = 1'b0;
        out_load      = 1'b0;
        res_next      = '0;
        res_next.last = 1'b1;
        count_next    = count_reg;
        trav_idx_next = trav_idx_reg;
        for (int i = 0; i < bpl_pkg::CAPACITY; i++) begin
            cells_next[i] = cells_reg[i];
        end
        case (state_reg)
            bpl_pkg::BK_IDLE: begin
                if (q_valid && can_load) begin
                    pop = 1'b1;
                    case (q_op.kind)
                        bpl_pkg::OP_INS: begin
                            out_load = 1'b1;
                            if (full) begin
                                res_next.status = bpl_pkg::ST_FULL;
                            end else begin
                                // Open a gap at the insert point
                                for (int i = 1; i < bpl_pkg::CAPACITY; i++) begin
                                    if (bpl_pkg::CNT_W'(i) > ins_idx &&
                                        bpl_pkg::CNT_W'(i) <= count_reg) begin
                                        cells_next[i] = cells_reg[i-1];
                                    end
                                end
                                for (int i = 0; i < bpl_pkg::CAPACITY; i++) begin
                                    if (bpl_pkg::CNT_W'(i) == ins_idx) begin
                                        cells_next[i] = q_op.word;
                                    end
                                end
                                count_next = count_reg + bpl_pkg::CNT_W'(1);
                            end
                        end
                        bpl_pkg::OP_DEL: begin
                            out_load = 1'b1;
                            if (empty) begin
                                res_next.status = bpl_pkg::ST_EMPTY;
                            end else if (range_err) begin
                                res_next.status = bpl_pkg::ST_RANGE;
                            end else begin
                                res_next.value = bpl_pkg::to_field(rd_word);
                                // Close the gap left by the removed cell
                                for (int i = 0; i < bpl_pkg::CAPACITY - 1; i++) begin
                                    if (bpl_pkg::CNT_W'(i) >= del_idx &&
                                        bpl_pkg::CNT_W'(i + 1) < count_reg) begin
                                        cells_next[i] = cells_reg[i+1];
                                    end
                                end
                                count_next = count_reg - bpl_pkg::CNT_W'(1);
                            end
                        end
                        bpl_pkg::OP_TRAV: begin
                            if (empty) begin
                                out_load        = 1'b1;
                                res_next.status = bpl_pkg::ST_EMPTY;
                            end else begin
                                trav_idx_next = '0;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            bpl_pkg::BK_FWD: begin
                if (can_load) begin
                    out_load       = 1'b1;
                    res_next.value = bpl_pkg::to_field(rd_word);
                    res_next.last  = 1'b0;
                    if (!trav_at_tail) begin
                        trav_idx_next = trav_idx_reg + bpl_pkg::IDX_W'(1);
                    end
                end
            end
            bpl_pkg::BK_BWD: begin
                if (can_load) begin
                    out_load           = 1'b1;
                    res_next.value     = bpl_pkg::to_field(rd_word);
                    res_next.direction = 1'b1;
                    res_next.last      = trav_at_head;
                    if (!trav_at_head) begin
                        trav_idx_next = trav_idx_reg - bpl_pkg::IDX_W'(1);
                    end
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    // Hold a result until the consumer takes it
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bpl_pkg::BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            trav_idx_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            trav_idx_reg  <= trav_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_reg <= res_next;
        end
        for (int i = 0; i < bpl_pkg::CAPACITY; i++) begin
            cells_reg[i] <= cells_next[i];
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bpl_pkg::CNT_W'(bpl_pkg::CAPACITY))
        else $error("list count above capacity");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != bpl_pkg::BK_IDLE) |-> !pop)
        else $error("request taken during traversal");

    a_count_only_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> count_reg == $past(count_reg))
        else $error("count changed without a request");

    a_trav_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpl_pkg::BK_BWD && out_load && trav_at_head)
        |=> (state_reg == bpl_pkg::BK_IDLE && res_reg.last))
        else $error("traversal did not finish with last");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |-> !out_load)
        else $error("pending result overwritten");
`endif

endmodule
